@@ rtl/core/aic_pkg.sv @@
// Shared types, character codes and constant helpers for the ASCII infix calculator.
// Used by aic_div, aic_dpath, aic_ctrl and ascii_infix_calculator_core.
package aic_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 16;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam longint unsigned RADIX = 10;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } term_op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the accepted character
    logic char_act;    // apply a character that completes no number
    logic fin_start;   // complete the pending number (starts the divider for /)
    logic fin_div_wr;  // write the quotient back into the term
    logic post;        // apply the operator after a number was completed
    logic total;       // form the final sum and its magnitude
    logic conv_sub;    // subtract the current power of ten once
    logic conv_skip;   // drop a leading zero position
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the current digit into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_pm;
    logic is_md;
    logic number_active;
    logic op_div;
    logic last;
    logic div_done;
    logic neg;
    logic ge_pow;
    logic need_emit;
    logic k_zero;
    logic out_free;
  } status_t;

  // Decimal digits needed for the largest magnitude, 2^(w-1)
  function automatic int unsigned num_digits(input int unsigned w);
    longint unsigned v;
    int unsigned     n;
    v = longint'(1) << (w - 1);
    n = 1;
    for (int i = 0; i < 20; i++) begin
      if (v >= RADIX) begin
        v = v / RADIX;
        n = n + 1;
      end
    end
    return n;
  endfunction

  function automatic longint unsigned pow10(input int unsigned k);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < 20; i++) begin
      if (i < k) begin
        r = r * RADIX;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/aic_div.sv @@
// Iterative restoring divider, signed, truncating toward zero, one quotient bit a cycle.
// Depends on aic_pkg.
module aic_div import aic_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic                   div_zero_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          dz_q, dz_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  mb_q, mb_d;

  logic          na, nb;
  logic [W-1:0]  ma, mb;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign na    = dividend_i[W-1];
  assign nb    = divisor_i[W-1];
  assign ma    = na ? (~dividend_i + 1'b1) : dividend_i;
  assign mb    = nb ? (~divisor_i + 1'b1) : divisor_i;
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, mb_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    dz_d   = dz_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mb_d   = mb_q;
    if (start_i) begin
      if (mb == '0) begin
        dz_d   = 1'b1;
        neg_d  = 1'b0;
        quo_d  = '0;
        done_d = 1'b1;
      end else begin
        dz_d   = 1'b0;
        neg_d  = na ^ nb;
        busy_d = 1'b1;
        cnt_d  = CW'(W - 1);
        rem_d  = '0;
        quo_d  = ma;
        mb_d   = mb;
      end
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dz_q   <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      dz_q   <= dz_d;
      neg_q  <= neg_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    mb_q  <= mb_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign div_zero_o = dz_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still iterating");

endmodule

@@ rtl/core/aic_dpath.sv @@
// Datapath: expression state, multiplier, divider, decimal conversion, output register.
// Depends on aic_pkg and aic_div; driven by aic_ctrl through cmd_t.
module aic_dpath import aic_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  input  logic [7:0] in_char_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic       div_zero_o
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned NDIG  = num_digits(W);
  localparam int unsigned KW    = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [KW-1:0] K_TOP = KW'(NDIG - 1);

  logic [7:0]    char_q, char_d;
  logic          last_q, last_d;
  logic [W-1:0]  sum_q, sum_d;
  logic [W-1:0]  term_q, term_d;
  term_op_e      op_q, op_d;
  logic          nneg_q, nneg_d;
  logic [W-1:0]  num_q, num_d;
  logic          active_q, active_d;
  logic          err_q, err_d;
  logic [W-1:0]  mag_q, mag_d;
  logic [KW-1:0] k_q, k_d;
  logic [3:0]    digit_q, digit_d;
  logic          started_q, started_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_last_q, out_last_d;
  logic          out_dz_q, out_dz_d;

  logic          is_digit, is_pm, is_md;
  logic [3:0]    char_digit;
  term_op_e      md_op;
  logic [W-1:0]  num_x10;
  logic [W-1:0]  num_signed;
  logic [2*W-1:0] prod;
  logic [W-1:0]  total;
  logic          total_neg;
  logic [W-1:0]  pow_tab [NDIG];
  logic [W-1:0]  pow_sel;
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_quo;
  logic          div_dz;

  for (genvar i = 0; i < NDIG; i++) begin : g_pow
    assign pow_tab[i] = W'(pow10(i));
  end

  assign is_digit   = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
  assign is_pm      = (char_q == CH_PLUS) || (char_q == CH_MINUS);
  assign is_md      = (char_q == CH_STAR) || (char_q == CH_SLASH);
  assign char_digit = char_q[3:0];
  assign md_op      = (char_q == CH_STAR) ? OP_MUL : OP_DIV;
  assign num_x10    = {num_q[W-4:0], 3'b000} + {num_q[W-2:0], 1'b0};
  assign num_signed = nneg_q ? (~num_q + 1'b1) : num_q;
  assign prod       = {{W{1'b0}}, term_q} * {{W{1'b0}}, num_signed};
  assign total      = sum_q + term_q;
  assign total_neg  = total[W-1];
  assign pow_sel    = pow_tab[k_q];
  assign div_start  = cmd_i.fin_start && (op_q == OP_DIV);

  aic_div #(
    .VALUE_WIDTH(W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(term_q),
    .divisor_i (num_signed),
    .done_o    (div_done),
    .quotient_o(div_quo),
    .div_zero_o(div_dz)
  );

  always_comb begin
    char_d      = char_q;
    last_d      = last_q;
    sum_d       = sum_q;
    term_d      = term_q;
    op_d        = op_q;
    nneg_d      = nneg_q;
    num_d       = num_q;
    active_d    = active_q;
    err_d       = err_q;
    mag_d       = mag_q;
    k_d         = k_q;
    digit_d     = digit_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_dz_d    = out_dz_q;

    if (cmd_i.capture) begin
      char_d = in_char_i;
      last_d = last_char_i;
    end

    if (cmd_i.char_act) begin
      if (is_digit) begin
        num_d    = num_x10 + W'(char_digit);
        active_d = 1'b1;
      end else if (char_q == CH_MINUS) begin
        nneg_d = !nneg_q;
      end else if (is_md) begin
        op_d = md_op;
      end
    end

    if (cmd_i.fin_start) begin
      unique case (op_q)
        OP_MUL:  term_d = prod[W-1:0];
        OP_DIV:  term_d = term_q;  // quotient arrives later
        default: term_d = num_signed;
      endcase
      num_d    = '0;
      active_d = 1'b0;
      nneg_d   = 1'b0;
    end

    if (cmd_i.fin_div_wr) begin
      term_d = div_quo;
      if (div_dz) begin
        err_d = 1'b1;
      end
    end

    if (cmd_i.post) begin
      if (is_pm) begin
        sum_d  = total;
        term_d = '0;
        op_d   = OP_NONE;
        nneg_d = (char_q == CH_MINUS);
      end else if (is_md) begin
        op_d = md_op;
      end
    end

    if (cmd_i.total) begin
      mag_d     = total_neg ? (~total + 1'b1) : total;
      k_d       = K_TOP;
      digit_d   = '0;
      started_d = 1'b0;
    end

    if (cmd_i.conv_sub) begin
      mag_d   = mag_q - pow_sel;
      digit_d = digit_q + 4'd1;
    end

    if (cmd_i.conv_skip) begin
      k_d = k_q - KW'(1);
    end

    if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      out_char_d  = CH_MINUS;
      out_last_d  = 1'b0;
      out_dz_d    = err_q;
    end

    if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      out_char_d  = CH_ZERO + 8'(digit_q);
      out_last_d  = (k_q == '0);
      out_dz_d    = err_q;
      started_d   = 1'b1;
      digit_d     = '0;
      if (k_q == '0) begin
        // last character out: return the expression state to reset
        sum_d    = '0;
        term_d   = '0;
        op_d     = OP_NONE;
        nneg_d   = 1'b0;
        num_d    = '0;
        active_d = 1'b0;
        err_d    = 1'b0;
      end else begin
        k_d = k_q - KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      term_q      <= '0;
      op_q        <= OP_NONE;
      nneg_q      <= 1'b0;
      num_q       <= '0;
      active_q    <= 1'b0;
      err_q       <= 1'b0;
      k_q         <= '0;
      digit_q     <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      term_q      <= term_d;
      op_q        <= op_d;
      nneg_q      <= nneg_d;
      num_q       <= num_d;
      active_q    <= active_d;
      err_q       <= err_d;
      k_q         <= k_d;
      digit_q     <= digit_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    last_q     <= last_d;
    mag_q      <= mag_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_dz_q   <= out_dz_d;
  end

  assign status_o.is_pm         = is_pm;
  assign status_o.is_md         = is_md;
  assign status_o.number_active = active_q;
  assign status_o.op_div        = (op_q == OP_DIV);
  assign status_o.last          = last_q;
  assign status_o.div_done      = div_done;
  assign status_o.neg           = total_neg;
  assign status_o.ge_pow        = (mag_q >= pow_sel);
  assign status_o.need_emit     = (digit_q != '0) || started_q || (k_q == '0);
  assign status_o.k_zero        = (k_q == '0);
  assign status_o.out_free      = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign div_zero_o  = out_dz_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_digit || cmd_i.emit_sign) |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before its transaction");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q <= 4'd9)
    else $error("conversion digit above nine");

endmodule

@@ rtl/core/aic_ctrl.sv @@
// Controller state machine: sequences character handling, number completion and output.
// Depends on aic_pkg; talks to aic_dpath through cmd_t and status_t only.
module aic_ctrl import aic_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHAR,
    ST_FIN,
    ST_DIV,
    ST_POST,
    ST_LAST,
    ST_TOTAL,
    ST_SIGN,
    ST_CONV
  } state_e;

  state_e state_q, state_d;
  logic   end_q, end_d;   // completing the number at the end of the expression

  always_comb begin
    state_d    = state_q;
    end_d      = end_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if ((status_i.is_pm || status_i.is_md) && status_i.number_active) begin
          end_d   = 1'b0;
          state_d = ST_FIN;
        end else begin
          cmd_o.char_act = 1'b1;
          state_d        = ST_LAST;
        end
      end
      ST_FIN: begin
        cmd_o.fin_start = 1'b1;
        state_d         = status_i.op_div ? ST_DIV : ST_POST;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.fin_div_wr = 1'b1;
          state_d          = ST_POST;
        end
      end
      ST_POST: begin
        if (end_q) begin
          state_d = ST_TOTAL;
        end else begin
          cmd_o.post = 1'b1;
          state_d    = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!status_i.last) begin
          state_d = ST_IDLE;
        end else if (status_i.number_active) begin
          end_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        cmd_o.total = 1'b1;
        state_d     = status_i.neg ? ST_SIGN : ST_CONV;
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_CONV;
        end
      end
      ST_CONV: begin
        priority if (status_i.ge_pow) begin
          cmd_o.conv_sub = 1'b1;
        end else if (status_i.need_emit) begin
          // hold until the output register frees up
          if (status_i.out_free) begin
            cmd_o.emit_digit = 1'b1;
            if (status_i.k_zero) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          cmd_o.conv_skip = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
    end
  end

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide wait");

endmodule

@@ rtl/core/ascii_infix_calculator_core.sv @@
// Sequencing: a character passes through accept, decode and wrap-up; completing a number adds
// finish and post steps, plus a wait while a divide is pending (one quotient bit a cycle).
// The last character adds a step for the sum, then repeated power-of-ten subtraction for each
// output digit position.
// Throughput: one character at a time; a new character is taken while a result waits.
// Reset: asynchronous, active low; clears all expression state and the output valid flag.
module ascii_infix_calculator_core import aic_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic       div_zero_o
);

  cmd_t    cmd;
  status_t status;

  aic_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  aic_dpath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_char_i  (in_char_i),
    .last_char_i(last_char_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o),
    .div_zero_o (div_zero_o)
  );

endmodule
